FILE: hdl/gar_pkg.sv
// ----------------------------------------------------------------------------
// gar_pkg - shared types and constants of the advantage recurrence
// Configuration defaults, register indexes, multiplier operand codes and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package gar_pkg;

	localparam int unsigned COEF_W     = 32; // widest coefficient (reward scale)
	localparam int unsigned COEF_FRAC  = 16; // fraction bits of every coefficient
	localparam int unsigned GAMMA_W    = 17; // discount and trace decay, Q1.16
	localparam int unsigned CLIP_W     = 31;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned SUM_EXTRA  = 15; // totals are this much wider than data
	localparam int unsigned STEP_W     = 3;  // four products, two halves each

	localparam logic [GAMMA_W-1:0] DISCOUNT_RST    = 17'd64880;
	localparam logic [GAMMA_W-1:0] TRACE_DECAY_RST = 17'd62259;
	localparam logic [COEF_W-1:0]  INV_STD_RST     = 32'd65536;
	localparam logic [CLIP_W-1:0]  CLIP_RST        = 31'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DISCOUNT    = 3'd0,
		CFG_TRACE_DECAY = 3'd1,
		CFG_STANDARDIZE = 3'd2,
		CFG_INV_STD     = 3'd3,
		CFG_CLIP        = 3'd4
	} cfg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE  = 2'd0,
		KIND_END   = 2'd1,
		KIND_TRUNC = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		MOP_REWARD = 2'd0,
		MOP_NEXT   = 2'd1,
		MOP_RETURN = 2'd2,
		MOP_ADV    = 2'd3
	} mul_op_t;

	typedef struct packed {
		logic [GAMMA_W-1:0] discount;
		logic [GAMMA_W-1:0] gl;
		logic               standardize;
		logic [COEF_W-1:0]  inv_std;
		logic [CLIP_W-1:0]  clip;
	} cfg_t;

	typedef struct packed {
		logic    load;
		logic    mul_go;
		mul_op_t mul_op;
		logic    mul_hi;
		logic    fin1;
		logic    fin2;
		logic    fin3;
		logic    fin4;
		logic    fin5;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage

FILE: hdl/gae_advantage_recurrence.sv
// One input word is processed at a time; the single shared multiplier forms four
// products per word, each as two half-width partial products, and five finishing
// add/saturate steps follow. A waiting result does not block the next input word
// until the following result is ready.
// Reset (arst_n low): recurrence state and totals clear, registers take defaults.
// ----------------------------------------------------------------------------
// gae_advantage_recurrence - generalized advantage estimation, top level
// Backward recurrence over timesteps producing advantage, return, target value
// and absolute-reward totals in signed fixed point with saturation.
// ----------------------------------------------------------------------------
module gae_advantage_recurrence #(
	parameter int unsigned DATA_WIDTH = 32,
	localparam int unsigned SUM_W = DATA_WIDTH + gar_pkg::SUM_EXTRA,
	localparam int unsigned IN_W  = ((3 * DATA_WIDTH + 7) / 8) * 8,
	localparam int unsigned OUT_W = ((3 * DATA_WIDTH + 2 * SUM_W + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [gar_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gar_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [IN_W-1:0]                    s_tdata,  // reward, value_pred, bootstrap_value
	input  logic [2:0]                         s_tuser,  // terminal_kind, batch_start
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [OUT_W-1:0]                   m_tdata,  // advantage, discounted_return,
	                                                     // target_value, abs_reward_total,
	                                                     // abs_clipped_total
	output logic [0:0]                         m_tuser   // error
);

	gar_pkg::cfg_t cfg;
	gar_pkg::cmd_t cmd;
	gar_pkg::sts_t sts;

	logic signed [DATA_WIDTH-1:0] advantage;
	logic signed [DATA_WIDTH-1:0] discounted_return;
	logic signed [DATA_WIDTH-1:0] target_value;
	logic [SUM_W-1:0]             abs_reward_total;
	logic [SUM_W-1:0]             abs_clipped_total;
	logic                         error;

	gar_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	gar_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	gar_dp #(
		.DW(DATA_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg               (cfg),
		.reward            (s_tdata[DATA_WIDTH-1:0]),
		.terminal_kind     (s_tuser[1:0]),
		.value_pred        (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
		.bootstrap_value   (s_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
		.batch_start       (s_tuser[2]),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.advantage         (advantage),
		.discounted_return (discounted_return),
		.target_value      (target_value),
		.abs_reward_total  (abs_reward_total),
		.abs_clipped_total (abs_clipped_total),
		.error             (error)
	);

	assign m_tdata = OUT_W'({abs_clipped_total, abs_reward_total, target_value,
		discounted_return, advantage});
	assign m_tuser = error;

endmodule

FILE: hdl/gar_cfg.sv
// ----------------------------------------------------------------------------
// gar_cfg - configuration registers
// Write-only register file and the registered gamma*lambda product.
// ----------------------------------------------------------------------------
module gar_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                we,
	input  logic [gar_pkg::CFG_IDX_W-1:0]       index,
	input  logic [gar_pkg::CFG_DATA_W-1:0]      data,
	output gar_pkg::cfg_t                       cfg
);

	localparam int unsigned GL_PROD_W = 2 * gar_pkg::GAMMA_W;

	logic [gar_pkg::GAMMA_W-1:0] discount_q;
	logic [gar_pkg::GAMMA_W-1:0] trace_decay_q;
	logic                        standardize_q;
	logic [gar_pkg::COEF_W-1:0]  inv_std_q;
	logic [gar_pkg::CLIP_W-1:0]  clip_q;
	logic [gar_pkg::GAMMA_W-1:0] gl_q;
	logic [GL_PROD_W-1:0]        gl_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discount_q    <= gar_pkg::DISCOUNT_RST;
			trace_decay_q <= gar_pkg::TRACE_DECAY_RST;
			standardize_q <= 1'b0;
			inv_std_q     <= gar_pkg::INV_STD_RST;
			clip_q        <= gar_pkg::CLIP_RST;
		end else if (we) begin
			unique case (gar_pkg::cfg_idx_t'(index))
				gar_pkg::CFG_DISCOUNT:    discount_q    <= data[gar_pkg::GAMMA_W-1:0];
				gar_pkg::CFG_TRACE_DECAY: trace_decay_q <= data[gar_pkg::GAMMA_W-1:0];
				gar_pkg::CFG_STANDARDIZE: standardize_q <= data[0];
				gar_pkg::CFG_INV_STD:     inv_std_q     <= data[gar_pkg::COEF_W-1:0];
				gar_pkg::CFG_CLIP:        clip_q        <= data[gar_pkg::CLIP_W-1:0];
				default: ;
			endcase
		end
	end

	// gamma*lambda, truncated back to Q1.16 and then registered in gl_q
	assign gl_prod = GL_PROD_W'(discount_q) * GL_PROD_W'(trace_decay_q);

	always_ff @(posedge clk) begin
		gl_q <= gl_prod[gar_pkg::COEF_FRAC+gar_pkg::GAMMA_W-1:gar_pkg::COEF_FRAC];
	end

	assign cfg.discount    = discount_q;
	assign cfg.gl          = gl_q;
	assign cfg.standardize = standardize_q;
	assign cfg.inv_std     = inv_std_q;
	assign cfg.clip        = clip_q;

endmodule

FILE: hdl/gar_mul.sv
// ----------------------------------------------------------------------------
// gar_mul - shared coefficient multiplier
// Sign-magnitude product of a data word and an unsigned Q.16 coefficient,
// built from two half-width partial products, truncated toward zero and
// saturated to the data range.
// ----------------------------------------------------------------------------
module gar_mul #(
	parameter int unsigned DW = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  gar_pkg::mul_op_t            op,
	input  logic                        hi,
	input  logic signed [DW-1:0]        a,
	input  logic [gar_pkg::COEF_W-1:0]  b,
	output logic                        done,
	output gar_pkg::mul_op_t            done_op,
	output logic signed [DW-1:0]        res
);

	localparam int unsigned HALF   = (DW + 1) / 2;
	localparam int unsigned PP_W   = HALF + gar_pkg::COEF_W;
	localparam int unsigned FULL_W = DW + gar_pkg::COEF_W;
	localparam int unsigned RES_W  = FULL_W - gar_pkg::COEF_FRAC;

	localparam logic [RES_W-1:0] POS_LIM = {{(RES_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic [RES_W-1:0] NEG_LIM = {{(RES_W-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

	logic [DW-1:0]     mag;
	logic [HALF-1:0]   chunk;
	logic [PP_W-1:0]   pp_s1;
	logic [PP_W-1:0]   acc_q;
	logic              v_s1;
	logic              hi_s1;
	logic              neg_s1;
	gar_pkg::mul_op_t  op_s1;
	logic [FULL_W-1:0] full;
	logic [RES_W-1:0]  rmag;

	assign mag   = a[DW-1] ? ~a + 1'b1 : a;
	assign chunk = hi ? HALF'(mag[DW-1:HALF]) : mag[HALF-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= go;
		end
	end

	always_ff @(posedge clk) begin
		pp_s1  <= PP_W'(chunk) * PP_W'(b);
		hi_s1  <= hi;
		neg_s1 <= a[DW-1];
		op_s1  <= op;
	end

	// hold the low half until the high half arrives
	always_ff @(posedge clk) begin
		if (v_s1 && !hi_s1) begin
			acc_q <= pp_s1;
		end
	end

	assign full = FULL_W'(acc_q) + (FULL_W'(pp_s1) << HALF);
	assign rmag = full[FULL_W-1:gar_pkg::COEF_FRAC];

	always_comb begin
		if (neg_s1) begin
			if (rmag > NEG_LIM) begin
				res = {1'b1, {(DW-1){1'b0}}};
			end else begin
				res = ~rmag[DW-1:0] + 1'b1;
			end
		end else if (rmag > POS_LIM) begin
			res = {1'b0, {(DW-1){1'b1}}};
		end else begin
			res = rmag[DW-1:0];
		end
	end

	assign done    = v_s1 && hi_s1;
	assign done_op = op_s1;

endmodule

FILE: hdl/gar_dp.sv
// ----------------------------------------------------------------------------
// gar_dp - advantage recurrence datapath
// Input capture, recurrence state, product store, finishing arithmetic and
// the output register.
// ----------------------------------------------------------------------------
module gar_dp #(
	parameter int unsigned DW = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  gar_pkg::cmd_t                           cmd,
	output gar_pkg::sts_t                           sts,
	input  gar_pkg::cfg_t                           cfg,
	input  logic signed [DW-1:0]                    reward,
	input  logic [gar_pkg::KIND_W-1:0]              terminal_kind,
	input  logic signed [DW-1:0]                    value_pred,
	input  logic signed [DW-1:0]                    bootstrap_value,
	input  logic                                    batch_start,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [DW-1:0]                    advantage,
	output logic signed [DW-1:0]                    discounted_return,
	output logic signed [DW-1:0]                    target_value,
	output logic [DW+gar_pkg::SUM_EXTRA-1:0]        abs_reward_total,
	output logic [DW+gar_pkg::SUM_EXTRA-1:0]        abs_clipped_total,
	output logic                                    error
);

	localparam int unsigned SW      = DW + gar_pkg::SUM_EXTRA;
	localparam int unsigned SUM_T_W = SW + 1;
	localparam int unsigned CMP_W   = (DW > gar_pkg::CLIP_W) ? DW : gar_pkg::CLIP_W;

	localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

	function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] x,
			input logic signed [DW-1:0] y);
		logic [DW:0] t;
		t = {x[DW-1], x} + {y[DW-1], y};
		if (t[DW] != t[DW-1]) begin
			return t[DW] ? DMIN : DMAX;
		end
		return t[DW-1:0];
	endfunction

	function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] x,
			input logic signed [DW-1:0] y);
		logic [DW:0] t;
		t = {x[DW-1], x} - {y[DW-1], y};
		if (t[DW] != t[DW-1]) begin
			return t[DW] ? DMIN : DMAX;
		end
		return t[DW-1:0];
	endfunction

	function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] x);
		return x[DW-1] ? ~x + 1'b1 : x;
	endfunction

	function automatic logic [SW-1:0] sum_add(input logic [SW-1:0] s,
			input logic [DW-1:0] x);
		logic [SW:0] t;
		t = {1'b0, s} + SUM_T_W'(x);
		return t[SW] ? {SW{1'b1}} : t[SW-1:0];
	endfunction

	logic signed [DW-1:0]           reward_q;
	logic signed [DW-1:0]           value_q;
	logic signed [DW-1:0]           boot_q;
	logic [gar_pkg::KIND_W-1:0]     kind_q;
	logic                           start_q;

	logic signed [DW-1:0]           prev_adv_q;
	logic signed [DW-1:0]           prev_ret_q;
	logic signed [DW-1:0]           next_val_q;
	logic [SW-1:0]                  reward_sum_q;
	logic [SW-1:0]                  clipped_sum_q;

	logic signed [DW-1:0]           prod_q [4];
	logic signed [DW-1:0]           clipped_q;
	logic signed [DW-1:0]           ret_q;
	logic signed [DW-1:0]           pred_q;
	logic signed [DW-1:0]           delta_q;
	logic signed [DW-1:0]           adv_q;

	logic                           out_valid_q;
	logic signed [DW-1:0]           adv_out_q;
	logic signed [DW-1:0]           ret_out_q;
	logic signed [DW-1:0]           tgt_out_q;
	logic [SW-1:0]                  rsum_out_q;
	logic [SW-1:0]                  csum_out_q;
	logic                           err_out_q;

	logic                           is_end;
	logic                           is_trunc;
	logic                           is_term;
	logic signed [DW-1:0]           nv;
	logic signed [DW-1:0]           mul_a;
	logic [gar_pkg::COEF_W-1:0]     mul_b;
	logic                           mul_done;
	gar_pkg::mul_op_t               mul_done_op;
	logic signed [DW-1:0]           mul_res;

	logic signed [DW-1:0]           cur;
	logic [CMP_W-1:0]               clip_ext;
	logic [CMP_W-1:0]               dmax_ext;
	logic signed [DW-1:0]           lim;
	logic signed [DW-1:0]           neg_lim;
	logic signed [DW-1:0]           cur_clip;

	assign is_end   = kind_q == gar_pkg::KIND_END;
	assign is_trunc = kind_q == gar_pkg::KIND_TRUNC;
	assign is_term  = is_end || is_trunc;

	always_comb begin
		if (is_trunc) begin
			nv = boot_q;
		end else if (is_end) begin
			nv = '0;
		end else begin
			nv = next_val_q;
		end
	end

	always_comb begin
		unique case (cmd.mul_op)
			gar_pkg::MOP_REWARD: begin
				mul_a = reward_q;
				mul_b = cfg.inv_std;
			end
			gar_pkg::MOP_NEXT: begin
				mul_a = nv;
				mul_b = gar_pkg::COEF_W'(cfg.discount);
			end
			gar_pkg::MOP_RETURN: begin
				mul_a = prev_ret_q;
				mul_b = gar_pkg::COEF_W'(cfg.discount);
			end
			gar_pkg::MOP_ADV: begin
				mul_a = prev_adv_q;
				mul_b = gar_pkg::COEF_W'(cfg.gl);
			end
		endcase
	end

	gar_mul #(
		.DW(DW)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (cmd.mul_go),
		.op      (cmd.mul_op),
		.hi      (cmd.mul_hi),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.done_op (mul_done_op),
		.res     (mul_res)
	);

	always_ff @(posedge clk) begin
		if (mul_done) begin
			prod_q[mul_done_op] <= mul_res;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			reward_q <= reward;
			kind_q   <= terminal_kind;
			value_q  <= value_pred;
			boot_q   <= bootstrap_value;
			start_q  <= batch_start;
		end
	end

	// reward scaled and clipped if standardize; limit kept in data range
	assign cur      = cfg.standardize ? prod_q[gar_pkg::MOP_REWARD] : reward_q;
	assign clip_ext = CMP_W'(cfg.clip);
	assign dmax_ext = CMP_W'(DMAX);
	assign lim      = (clip_ext > dmax_ext) ? DMAX : DW'(clip_ext);
	assign neg_lim  = ~lim + 1'b1;

	always_comb begin
		if (!cfg.standardize || cfg.clip == '0) begin
			cur_clip = cur;
		end else if (cur > lim) begin
			cur_clip = lim;
		end else if (cur < neg_lim) begin
			cur_clip = neg_lim;
		end else begin
			cur_clip = cur;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin1) begin
			clipped_q <= cur_clip;
			ret_q     <= is_term ? reward_q : sat_add(reward_q, prod_q[gar_pkg::MOP_RETURN]);
		end
		if (cmd.fin2) begin
			pred_q <= is_end ? clipped_q : sat_add(clipped_q, prod_q[gar_pkg::MOP_NEXT]);
		end
		if (cmd.fin3) begin
			delta_q <= sat_sub(pred_q, value_q);
		end
		if (cmd.fin4) begin
			adv_q <= is_term ? delta_q : sat_add(delta_q, prod_q[gar_pkg::MOP_ADV]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_adv_q    <= '0;
			prev_ret_q    <= '0;
			next_val_q    <= '0;
			reward_sum_q  <= '0;
			clipped_sum_q <= '0;
		end else begin
			// a batch start clears the recurrence before its own step
			if (cmd.load && batch_start) begin
				prev_adv_q    <= '0;
				prev_ret_q    <= '0;
				next_val_q    <= '0;
				reward_sum_q  <= '0;
				clipped_sum_q <= '0;
			end
			if (cmd.fin1) begin
				reward_sum_q <= sum_add(reward_sum_q, mag_of(cur));
			end
			if (cmd.fin2 && cfg.standardize) begin
				clipped_sum_q <= sum_add(clipped_sum_q, mag_of(clipped_q));
			end
			if (cmd.fin5) begin
				prev_adv_q <= adv_q;
				prev_ret_q <= ret_q;
				next_val_q <= value_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin5) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin5) begin
			adv_out_q  <= adv_q;
			ret_out_q  <= ret_q;
			tgt_out_q  <= sat_add(value_q, adv_q);
			rsum_out_q <= reward_sum_q;
			csum_out_q <= clipped_sum_q;
			err_out_q  <= start_q && !is_term;
		end
	end

	assign sts.out_busy      = out_valid_q && !out_ready;
	assign out_valid         = out_valid_q;
	assign advantage         = adv_out_q;
	assign discounted_return = ret_out_q;
	assign target_value      = tgt_out_q;
	assign abs_reward_total  = rsum_out_q;
	assign abs_clipped_total = csum_out_q;
	assign error             = err_out_q;

endmodule

FILE: hdl/gar_ctrl.sv
// ----------------------------------------------------------------------------
// gar_ctrl - advantage recurrence controller
// Sequences one word: capture, eight partial products and five finishing steps,
// the last of which hands the result over to the output register.
// ----------------------------------------------------------------------------
module gar_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output gar_pkg::cmd_t cmd,
	input  gar_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_F1,
		ST_F2,
		ST_F3,
		ST_F4,
		ST_F5
	} state_t;

	state_t                     state_q;
	logic [gar_pkg::STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_MUL;
						step_q  <= '0;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == '1) begin
						state_q <= ST_F1;
					end
				end
				ST_F1: state_q <= ST_F2;
				ST_F2: state_q <= ST_F3;
				ST_F3: state_q <= ST_F4;
				ST_F4: state_q <= ST_F5;
				ST_F5: begin
					// hold while the previous result still waits
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && s_tvalid;
		cmd.mul_go = state_q == ST_MUL;
		cmd.mul_op = gar_pkg::mul_op_t'(step_q[2:1]);
		cmd.mul_hi = step_q[0];
		cmd.fin1   = state_q == ST_F1;
		cmd.fin2   = state_q == ST_F2;
		cmd.fin3   = state_q == ST_F3;
		cmd.fin4   = state_q == ST_F4;
		cmd.fin5   = (state_q == ST_F5) && !sts.out_busy;
	end

	assign s_tready = state_q == ST_IDLE;

endmodule

FILE: verif/gae_advantage_recurrence_test.sv
// ----------------------------------------------------------------------------
// gae_advantage_recurrence_test - self-checking bench for the advantage block
// Feeds timestep words in batches through the slave stream, predicts every
// result word from its own fixed-point model of the backward recurrence and
// compares the master stream field by field, under several register settings,
// random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module gae_advantage_recurrence_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DW    = 32;
	localparam int unsigned SUM_W = DW + gar_pkg::SUM_EXTRA;
	localparam int unsigned IN_W  = ((3 * DW + 7) / 8) * 8;
	localparam int unsigned OUT_W = ((3 * DW + 2 * SUM_W + 7) / 8) * 8;

	localparam logic [gar_pkg::KIND_W-1:0] KIND_SPARE = 2'd3; // unused code, not terminal
	localparam logic [DW-1:0] WORD_MAX = {1'b0, {(DW - 1){1'b1}}};
	localparam logic [DW-1:0] WORD_MIN = {1'b1, {(DW - 1){1'b0}}};
	localparam longint DATA_MAX = (longint'(1) << (DW - 1)) - 1;
	localparam longint DATA_MIN = -DATA_MAX - 1;
	localparam longint unsigned TOTAL_MAX   = (64'd1 << SUM_W) - 1;
	localparam longint unsigned PRODUCT_CAP = 64'd1 << 62;
	localparam int unsigned HOLD_CYCLES = 400;

	typedef struct {
		logic signed [DW-1:0]          reward;
		logic [gar_pkg::KIND_W-1:0]    kind;
		logic signed [DW-1:0]          value;
		logic signed [DW-1:0]          boot;
		logic                          start;
	} timestep_t;

	typedef struct {
		logic [DW-1:0]    adv;
		logic [DW-1:0]    ret;
		logic [DW-1:0]    tgt;
		logic [SUM_W-1:0] reward_total;
		logic [SUM_W-1:0] clip_total;
		logic             err;
	} estimate_t;

	class advantage_scoreboard;
		logic [gar_pkg::GAMMA_W-1:0] gamma;
		logic [gar_pkg::GAMMA_W-1:0] lambda;
		logic                        std_on;
		logic [gar_pkg::COEF_W-1:0]  inv_std;
		logic [gar_pkg::CLIP_W-1:0]  clip_lim;
		longint                      adv_prev;
		longint                      ret_prev;
		longint                      value_next;
		longint unsigned             reward_total;
		longint unsigned             clip_total;
		estimate_t                   pending_q[$];
		int                          failures;

		function new();
			gamma        = gar_pkg::DISCOUNT_RST;
			lambda       = gar_pkg::TRACE_DECAY_RST;
			std_on       = 1'b0;
			inv_std      = gar_pkg::INV_STD_RST;
			clip_lim     = gar_pkg::CLIP_RST;
			adv_prev     = 0;
			ret_prev     = 0;
			value_next   = 0;
			reward_total = 0;
			clip_total   = 0;
			failures     = 0;
		endfunction

		function void set_register(gar_pkg::cfg_idx_t idx,
				logic [gar_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				gar_pkg::CFG_DISCOUNT:    gamma    = val[gar_pkg::GAMMA_W-1:0];
				gar_pkg::CFG_TRACE_DECAY: lambda   = val[gar_pkg::GAMMA_W-1:0];
				gar_pkg::CFG_STANDARDIZE: std_on   = val[0];
				gar_pkg::CFG_INV_STD:     inv_std  = val[gar_pkg::COEF_W-1:0];
				gar_pkg::CFG_CLIP:        clip_lim = val[gar_pkg::CLIP_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp_data(longint v);
			if (v > DATA_MAX)
				return DATA_MAX;
			if (v < DATA_MIN)
				return DATA_MIN;
			return v;
		endfunction

		function longint unsigned magnitude(longint v);
			return (v < 0) ? longint'(-v) : v;
		endfunction

		// magnitude times coefficient, truncated towards zero, sign put back
		function longint scale(longint a, longint unsigned coef);
			longint unsigned m;
			longint unsigned hi_part;
			longint unsigned r;
			m       = magnitude(a);
			hi_part = (m >> 24) * coef;
			if (hi_part > (PRODUCT_CAP >> (24 - gar_pkg::COEF_FRAC)))
				r = PRODUCT_CAP;
			else
				r = (hi_part << (24 - gar_pkg::COEF_FRAC)) +
				    (((m & 64'hFF_FFFF) * coef) >> gar_pkg::COEF_FRAC);
			if (r > PRODUCT_CAP)
				r = PRODUCT_CAP;
			return clamp_data((a < 0) ? -longint'(r) : longint'(r));
		endfunction

		function longint unsigned add_total(longint unsigned s, longint unsigned x);
			if (s > TOTAL_MAX)
				s = TOTAL_MAX;
			if (x > TOTAL_MAX - s)
				return TOTAL_MAX;
			return s + x;
		endfunction

		function void note_step(timestep_t s);
			longint          r;
			longint          v;
			longint          boot;
			longint          cur;
			longint          nv;
			longint          pred;
			longint          delta;
			longint          ret;
			longint          adv;
			longint          lim;
			longint unsigned g64;
			longint unsigned l64;
			longint unsigned gl;
			logic            done;
			logic            trunc;
			estimate_t       e;
			r     = s.reward;
			v     = s.value;
			boot  = s.boot;
			done  = (s.kind == gar_pkg::KIND_END);
			trunc = (s.kind == gar_pkg::KIND_TRUNC);
			e.err = s.start && !done && !trunc;
			if (s.start) begin
				adv_prev     = 0;
				ret_prev     = 0;
				value_next   = 0;
				reward_total = 0;
				clip_total   = 0;
			end
			if (std_on) begin
				cur          = scale(r, inv_std);
				reward_total = add_total(reward_total, magnitude(cur));
				if (clip_lim != 0) begin
					lim = (clip_lim > DATA_MAX) ? DATA_MAX : longint'(clip_lim);
					if (cur > lim)
						cur = lim;
					if (cur < -lim)
						cur = -lim;
				end
				clip_total = add_total(clip_total, magnitude(cur));
			end else begin
				cur          = r;
				reward_total = add_total(reward_total, magnitude(cur));
			end
			if (trunc)
				nv = boot;
			else if (done)
				nv = 0;
			else
				nv = value_next;
			g64   = gamma;
			l64   = lambda;
			gl    = (g64 * l64) >> gar_pkg::COEF_FRAC;
			pred  = done ? cur : clamp_data(cur + scale(nv, g64));
			delta = clamp_data(pred - v);
			ret   = (done || trunc) ? r : clamp_data(r + scale(ret_prev, g64));
			adv   = (done || trunc) ? delta : clamp_data(delta + scale(adv_prev, gl));
			adv_prev   = adv;
			ret_prev   = ret;
			value_next = v;
			e.adv          = adv[DW-1:0];
			e.ret          = ret[DW-1:0];
			e.tgt          = DW'(clamp_data(v + adv));
			e.reward_total = reward_total[SUM_W-1:0];
			e.clip_total   = clip_total[SUM_W-1:0];
			pending_q.push_back(e);
		endfunction

		function void compare(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
				failures++;
			end
		endfunction

		function void check_word(logic [OUT_W-1:0] data, logic err);
			estimate_t e;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result word %h error %b", $time, data, err);
				failures++;
				return;
			end
			e = pending_q.pop_front();
			compare("advantage", 64'(e.adv), 64'(data[DW-1:0]));
			compare("discounted_return", 64'(e.ret), 64'(data[2*DW-1:DW]));
			compare("target_value", 64'(e.tgt), 64'(data[3*DW-1:2*DW]));
			compare("abs_reward_total", 64'(e.reward_total),
			        64'(data[3*DW+SUM_W-1:3*DW]));
			compare("abs_clipped_total", 64'(e.clip_total),
			        64'(data[3*DW+2*SUM_W-1:3*DW+SUM_W]));
			compare("error", 64'(e.err), 64'(err));
		endfunction
	endclass

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [gar_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [gar_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [IN_W-1:0]                s_tdata   = '0; // reward, value_pred, bootstrap_value
	logic [2:0]                     s_tuser   = '0; // terminal_kind, batch_start
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [OUT_W-1:0]               m_tdata;        // advantage, discounted_return,
	                                                // target_value, abs_reward_total,
	                                                // abs_clipped_total
	logic [0:0]                     m_tuser;        // error

	advantage_scoreboard tracker = new();
	bit hold_off  = 1'b0;
	int batch_left = 0;

	gae_advantage_recurrence #(
		.DATA_WIDTH(DW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_word(m_tdata, m_tuser[0]);
	end

	function automatic logic [DW-1:0] pick_data();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
			4:          return WORD_MAX;
			5:          return WORD_MIN;
			6:          return (($urandom_range(0, 1) != 0) ? '1 : '0);
			default:    return $urandom();
		endcase
	endfunction

	function automatic logic [gar_pkg::GAMMA_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return 17'd65536;
			2:       return 17'd65535;
			3:       return gar_pkg::DISCOUNT_RST;
			default: return gar_pkg::GAMMA_W'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [gar_pkg::COEF_W-1:0] pick_scale();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return '1;
			2:       return gar_pkg::INV_STD_RST;
			3:       return $urandom();
			default: return $urandom_range(32'h0000_1000, 32'h0004_0000);
		endcase
	endfunction

	function automatic logic [gar_pkg::CLIP_W-1:0] pick_clip();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return 31'd1;
			2:       return '1;
			3:       return gar_pkg::CLIP_W'($urandom());
			default: return gar_pkg::CLIP_W'($urandom_range(1, 32'h0010_0000));
		endcase
	endfunction

	// mostly well-formed batches: a terminal batch start, then earlier timesteps
	function automatic timestep_t next_step();
		timestep_t s;
		int        pick;
		s.reward = pick_data();
		s.value  = pick_data();
		s.boot   = pick_data();
		s.start  = 1'b0;
		s.kind   = gar_pkg::KIND_NONE;
		if (batch_left == 0) begin
			batch_left = $urandom_range(1, 40);
			s.start    = 1'b1;
			pick       = $urandom_range(0, 19);
			s.kind     = (pick < 9) ? gar_pkg::KIND_END : (pick < 18) ? gar_pkg::KIND_TRUNC :
			             (pick == 18) ? gar_pkg::KIND_NONE : KIND_SPARE;
		end else begin
			batch_left--;
			pick = $urandom_range(0, 49);
			if (pick < 3)
				s.kind = gar_pkg::KIND_END;
			else if (pick < 6)
				s.kind = gar_pkg::KIND_TRUNC;
			else if (pick == 6)
				s.kind = KIND_SPARE;
			else if (pick == 7)
				s.start = 1'b1;
		end
		return s;
	endfunction

	function automatic timestep_t make_step(logic [DW-1:0] reward,
	                                        logic [gar_pkg::KIND_W-1:0] kind,
	                                        logic [DW-1:0] value, logic [DW-1:0] boot,
	                                        logic start);
		timestep_t s;
		s.reward = reward;
		s.kind   = kind;
		s.value  = value;
		s.boot   = boot;
		s.start  = start;
		return s;
	endfunction

	task automatic write_reg(gar_pkg::cfg_idx_t idx, logic [gar_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		tracker.set_register(idx, val);
	endtask

	task automatic load_settings(logic [gar_pkg::GAMMA_W-1:0] gain,
	                             logic [gar_pkg::GAMMA_W-1:0] decay, logic std_en,
	                             logic [gar_pkg::COEF_W-1:0] inv,
	                             logic [gar_pkg::CLIP_W-1:0] clip);
		write_reg(gar_pkg::CFG_DISCOUNT, gar_pkg::CFG_DATA_W'(gain));
		write_reg(gar_pkg::CFG_TRACE_DECAY, gar_pkg::CFG_DATA_W'(decay));
		write_reg(gar_pkg::CFG_STANDARDIZE, gar_pkg::CFG_DATA_W'(std_en));
		write_reg(gar_pkg::CFG_INV_STD, inv);
		write_reg(gar_pkg::CFG_CLIP, gar_pkg::CFG_DATA_W'(clip));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic offer(timestep_t s);
		s_tvalid <= 1'b1;
		s_tdata  <= {s.boot, s.value, s.reward};
		s_tuser  <= {s.start, s.kind};
		do
			@(posedge clk);
		while (!s_tready);
		tracker.note_step(s);
	endtask

	task automatic pause_sender(int cycles);
		if (cycles > 0) begin
			s_tvalid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// hold the sender until every outstanding result word is back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (tracker.pending_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic send_random(int count);
		int burst = 0;
		repeat (count) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 32);
				pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
			end
			offer(next_step());
			burst--;
		end
	endtask

	task automatic directed_steps();
		offer(make_step(WORD_MAX, gar_pkg::KIND_END, WORD_MIN, '0, 1'b1));
		offer(make_step(WORD_MIN, gar_pkg::KIND_NONE, WORD_MAX, '0, 1'b0));
		offer(make_step('0, gar_pkg::KIND_NONE, '1, WORD_MAX, 1'b0));
		offer(make_step(32'h0001_0000, gar_pkg::KIND_TRUNC, '0, WORD_MAX, 1'b0));
		offer(make_step(WORD_MAX, gar_pkg::KIND_NONE, WORD_MAX, '0, 1'b0));
		// spare kind must ignore the bootstrap value
		offer(make_step(32'hFFFF_0000, KIND_SPARE, 32'd12345, WORD_MIN, 1'b0));
		offer(make_step(32'h0003_0000, gar_pkg::KIND_NONE, 32'h0001_0000, '0, 1'b1));
		offer(make_step(WORD_MIN, gar_pkg::KIND_NONE, WORD_MIN, '0, 1'b0));
		offer(make_step('1, KIND_SPARE, '0, '1, 1'b1));
		offer(make_step(WORD_MIN, gar_pkg::KIND_TRUNC, WORD_MAX, WORD_MIN, 1'b1));
		offer(make_step('0, gar_pkg::KIND_END, WORD_MAX, '0, 1'b0));
		offer(make_step(WORD_MAX, gar_pkg::KIND_NONE, '0, '0, 1'b0));
	endtask

	initial begin : receiver
		int ready_len;
		int stall_len;
		forever begin
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
			case ($urandom_range(0, 3))
				0: begin
					ready_len = $urandom_range(30, 200);
					stall_len = 0;
				end
				1: begin
					ready_len = $urandom_range(1, 3);
					stall_len = $urandom_range(1, 24);
				end
				default: begin
					ready_len = $urandom_range(1, 12);
					stall_len = $urandom_range(0, 6);
				end
			endcase
			m_tready <= 1'b1;
			repeat (ready_len) @(posedge clk);
			if (stall_len > 0) begin
				m_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_steps();
		settle();
		load_settings(17'd49152, 17'd65536, 1'b1, 32'h0002_0000, 31'h0001_8000);
		directed_steps();
		settle();
		load_settings(17'd65536, 17'd65536, 1'b1, '1, '1);
		send_random(250);
		settle();
		load_settings('0, '0, 1'b1, '0, 31'd1);
		send_random(250);
		settle();
		for (int phase = 0; phase < 4; phase++) begin
			load_settings(pick_gain(), pick_gain(),
			              (phase != 0) && ($urandom_range(0, 3) != 0),
			              pick_scale(), pick_clip());
			// stall the result side long enough to back up the input
			if (phase == 1)
				hold_off = 1'b1;
			send_random(250);
			settle();
		end
		if (tracker.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : watchdog
		#1_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: gae_advantage_recurrence.f
hdl/gar_pkg.sv
hdl/gar_cfg.sv
hdl/gar_mul.sv
hdl/gar_dp.sv
hdl/gar_ctrl.sv
hdl/gae_advantage_recurrence.sv
verif/gae_advantage_recurrence_test.sv
